/* hdl/jos_pkg.sv */
// jos_pkg: shared widths, register indexes, reset values and the cell command
// struct for the josephus elimination order block; no dependencies
`timescale 1ns / 1ps

package jos_pkg;

  localparam int MAX_PEOPLE_DEF = 64;

  localparam int SIZE_W   = 7;   // circle_size register
  localparam int STEP_W   = 10;  // step_count register
  localparam int PERSON_W = 7;   // removed_person field
  localparam int ADDR_W   = 1;
  localparam int DATA_W   = 10;

  localparam logic [ADDR_W-1:0] REG_CIRCLE_SIZE = 1'd0;
  localparam logic [ADDR_W-1:0] REG_STEP_COUNT  = 1'd1;

  localparam logic [SIZE_W-1:0] CIRCLE_SIZE_RST = 7'd7;
  localparam logic [STEP_W-1:0] STEP_COUNT_RST  = 10'd3;

  // command broadcast to every cell of the ring
  typedef struct packed {
    logic load;    // reload with own seat number
    logic rotate;  // front to back of the occupied part
    logic shift;   // drop the front, close the gap
  } cell_op_t;

endpackage

/* hdl/josephus_elimination_order.sv */
// josephus_elimination_order: top level, ring of seat cells, sequencer,
// output register; depends on jos_pkg, jos_cell, jos_rem
`timescale 1ns / 1ps

// Reports the Josephus elimination order, one removal per request. The circle
// lives in a row of MAX_PEOPLE seat cells; cell 0 is always the front of the
// queue and the occupied cells are 0..count-1. A request with restart set
// reloads every cell with its seat number 1..MAX_PEOPLE and sets the people
// left to circle_size (clamped to MAX_PEOPLE) in the accept cycle. The
// sequencer then reduces step_count-1 modulo the people left in a bit-serial
// remainder unit (one bit per cycle), rotates the ring by that remainder, one
// place per cycle (every cell takes its right neighbor, the last occupied cell
// takes the front), and finally removes the front by shifting the whole row
// one place toward the front.
// The rotation loop dominates the time from one accept to the next.
// The result is registered as the sequencer returns to idle, and a stalled
// result port adds its wait. A request on an empty circle answers none_left
// from the start state once the result port is free, and frees the input as
// that answer is registered.
// Requests are taken one at a time; the output register lets the next request
// enter while a result still waits.
// The ring needs no clearing after reset: a restart writes it before any read.
// Config writes (index 0 circle_size, index 1 step_count) are expected only
// while the block is idle.

module josephus_elimination_order
  import jos_pkg::*;
#(
  parameter int MAX_PEOPLE = MAX_PEOPLE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [DATA_W-1:0] cfg_wdata,
  // request stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [6:0] removed_person, [7] zero
  output logic              m_tlast,   // last_removal
  output logic              m_tuser    // none_left
);

  localparam int CW    = $clog2(MAX_PEOPLE + 1);
  localparam int CMP_W = (CW > SIZE_W) ? CW : SIZE_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_ROT    = 3'd3;
  localparam logic [2:0] ST_REMOVE = 3'd4;

  logic [2:0]        state;
  logic [SIZE_W-1:0] circle_size;
  logic [STEP_W-1:0] step_count;
  logic [CW-1:0]     count;      // people left
  logic [CW-1:0]     rot_cnt;    // rotations still to do
  logic [CW-1:0]     ring [MAX_PEOPLE];

  cell_op_t          op;
  logic              accept;
  logic              out_free;
  logic              remove_fire;
  logic              empty_fire;
  logic [CW-1:0]     load_count;
  logic [STEP_W-1:0] skip;
  logic              div_start;
  logic              div_done;
  logic [CW-1:0]     div_rem;
  logic [CW+PERSON_W-1:0] person_wide;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_size <= CIRCLE_SIZE_RST;
      step_count  <= STEP_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CIRCLE_SIZE: circle_size <= cfg_wdata[SIZE_W-1:0];
        REG_STEP_COUNT:  step_count  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and control decode
  assign s_tready    = (state == ST_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign remove_fire = (state == ST_REMOVE) && out_free;
  assign empty_fire  = (state == ST_START) && (count == '0) && out_free;
  assign div_start   = (state == ST_START) && (count != '0);

  // clamp the restart size to the ring length
  assign load_count = (CMP_W'(circle_size) > CMP_W'(MAX_PEOPLE)) ?
                      CW'(MAX_PEOPLE) : CW'(circle_size);

  // zero step behaves like one
  assign skip = (step_count == '0) ? '0 : step_count - STEP_W'(1);

  always_comb begin
    op.load   = accept && s_tdata[0];
    op.rotate = (state == ST_ROT) && (rot_cnt != '0);
    op.shift  = remove_fire;
  end

  // row of seat cells, each fed by its right neighbor
  for (genvar g = 0; g < MAX_PEOPLE; g++) begin : g_cell
    logic [CW-1:0] right_val;
    if (g == MAX_PEOPLE - 1) begin : g_end
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = ring[g+1];
    end
    jos_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (count),
      .front_val (ring[0]),
      .right_val (right_val),
      .val       (ring[g])
    );
  end

  // skip mod people left
  jos_rem #(
    .CW (CW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (skip),
    .divisor  (count),
    .done     (div_done),
    .rem      (div_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tdata[0]) begin
              count <= load_count;
            end
            state <= ST_START;
          end
        end
        ST_START: begin
          if (count != '0) begin
            state <= ST_DIV;
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            rot_cnt <= div_rem;
            state   <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (rot_cnt == '0) begin
            state <= ST_REMOVE;
          end else begin
            rot_cnt <= rot_cnt - CW'(1);
          end
        end
        ST_REMOVE: begin
          if (out_free) begin
            count <= count - CW'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // person numbers above 127 keep their low bits only
  assign person_wide = {{PERSON_W{1'b0}}, ring[0]};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (remove_fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, person_wide[PERSON_W-1:0]};
        m_tlast  <= (count == CW'(1));
        m_tuser  <= 1'b0;
      end else if (empty_fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= '0;
        m_tlast  <= 1'b0;
        m_tuser  <= 1'b1;
      end
    end
  end

  // a removal takes exactly one person
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    remove_fire |=> count == $past(count) - CW'(1))
    else $error("people count not decremented by removal");

  // the remainder never reaches the people left
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_rem < count)
    else $error("remainder out of range");

  // rotation count stays below the people left
  a_rot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROT) |-> rot_cnt < count)
    else $error("rotation count out of range");

  // a last removal never doubles as an empty answer
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && m_tuser))
    else $error("last_removal and none_left both set");

endmodule

/* hdl/jos_cell.sv */
// jos_cell: one seat of the ring, holds one person number
// depends on jos_pkg (cell_op_t)
`timescale 1ns / 1ps

module jos_cell
  import jos_pkg::*;
#(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_op_t      op,
  input  logic [CW-1:0] count,
  input  logic [CW-1:0] front_val,
  input  logic [CW-1:0] right_val,
  output logic [CW-1:0] val
);

  logic is_tail;

  // last occupied seat takes the front person on a rotation
  assign is_tail = (count == CW'(IDX + 1));

  always_ff @(posedge clk) begin
    if (op.load) begin
      val <= CW'(IDX + 1);
    end else if (op.rotate) begin
      val <= is_tail ? front_val : right_val;
    end else if (op.shift) begin
      val <= right_val;
    end
  end

endmodule

/* hdl/jos_rem.sv */
// jos_rem: bit-serial remainder of the skip count by the people left,
// one quotient bit per cycle; depends on jos_pkg (STEP_W)
`timescale 1ns / 1ps

module jos_rem
  import jos_pkg::*;
#(
  parameter int CW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [CW-1:0]     rem
);

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [STEP_W-1:0] dvd;
  logic [CW-1:0]     dsr;
  logic [CW:0]       trial;
  logic [CW:0]       diff;

  assign trial = {rem, dvd[STEP_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEP_W);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= (trial >= {1'b0, dsr}) ? diff[CW-1:0] : trial[CW-1:0];
        dvd <= dvd << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* tb/sv/josephus_elimination_order_test.sv */
// josephus_elimination_order_test: self-checking bench for the josephus
// elimination order block; needs jos_pkg and the josephus_elimination_order rtl
`timescale 1ns / 1ps

module josephus_elimination_order_test
  import jos_pkg::*;
();

  localparam int RING_MAX     = MAX_PEOPLE_DEF;
  localparam int RANDOM_ITEMS = 530;
  localparam int TAIL_ITEMS   = 60;
  // watchdog bound covers the worst requests plus the idle gaps on each side
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_WAIT  = 90;

  // one expected result: removed person, emptied-the-circle flag, none-left flag
  typedef struct packed {
    logic [PERSON_W-1:0] person;
    logic                last;
    logic                none;
  } removal_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;    // [0] restart, [7:1] zero
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;         // [6:0] removed_person, [7] zero
  logic              m_tlast;         // last_removal
  logic              m_tuser;         // none_left

  josephus_elimination_order dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // circle model: queue order held in seat_order, read circularly from front_seat
  // ---------------------------------------------------------------------------
  logic [PERSON_W-1:0] seat_order [RING_MAX];
  int unsigned         people_left = 0;
  int unsigned         front_seat = 0;
  logic [SIZE_W-1:0]   size_setting = CIRCLE_SIZE_RST;
  logic [STEP_W-1:0]   step_setting = STEP_COUNT_RST;

  removal_t    expected_removals [$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  bit          quiet_tail = 1'b0;

  function automatic removal_t predict_removal(input logic restart);
    int unsigned n;
    int unsigned skip;
    int unsigned pos;
    removal_t    r;
    if (restart) begin
      // oversize circles are clamped to the ring depth
      n = (size_setting > RING_MAX) ? RING_MAX : size_setting;
      for (int i = 0; i < n; i++) seat_order[i] = PERSON_W'(i + 1);
      people_left = n;
      front_seat  = 0;
    end
    if (people_left == 0 || people_left > RING_MAX || front_seat >= people_left) begin
      people_left = 0;
      front_seat  = 0;
      r = '{person: '0, last: 1'b0, none: 1'b1};
      return r;
    end
    // step zero behaves like step one: no rotation
    skip = (step_setting == 0) ? 0 : step_setting - 1;
    pos  = (front_seat + skip % people_left) % people_left;
    r.person = seat_order[pos];
    // people behind the removed one keep their order
    for (int i = pos; i + 1 < people_left; i++) seat_order[i] = seat_order[i + 1];
    people_left--;
    front_seat = (people_left == 0) ? 0 : pos % people_left;
    r.last = (people_left == 0);
    r.none = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, then compare with the oldest expectation
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    removal_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_removals.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result tdata=%0h tlast=%0b tuser=%0b",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          exp_r = expected_removals.pop_front();
          if (m_tdata !== {1'b0, exp_r.person}) begin
            mismatch_count++;
            $display("%0t: removed_person expected %0d actual tdata=%0h",
                     $time, exp_r.person, m_tdata);
          end
          if (m_tlast !== exp_r.last) begin
            mismatch_count++;
            $display("%0t: last_removal expected %0b actual %0b", $time, exp_r.last, m_tlast);
          end
          if (m_tuser !== exp_r.none) begin
            mismatch_count++;
            $display("%0t: none_left expected %0b actual %0b", $time, exp_r.none, m_tuser);
          end
        end
      end
      // ready pattern for the next edge
      if (quiet_tail) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shared request driver and helpers
  // ---------------------------------------------------------------------------

  // holds the request until taken, predicts it, then maybe idles the sender
  task automatic send_request(input logic restart);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!s_tready);
    expected_removals.push_back(predict_removal(restart));
    requests_sent++;
    if (requests_sent >= RANDOM_ITEMS - TAIL_ITEMS + 25) quiet_tail = 1'b1;
    if (!quiet_tail && $urandom_range(1, 100) <= sender_idle_pct) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_removals.size() != 0);
  endtask

  // register writes, block must be idle
  task automatic set_config(input bit wr_size, input logic [DATA_W-1:0] size_word,
                            input bit wr_step, input logic [DATA_W-1:0] step_word);
    if (wr_size) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= REG_CIRCLE_SIZE;
      cfg_wdata <= size_word;
      @(posedge clk);
      size_setting = size_word[SIZE_W-1:0];
    end
    if (wr_step) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= REG_STEP_COUNT;
      cfg_wdata <= step_word;
      @(posedge clk);
      step_setting = step_word[STEP_W-1:0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: empty circle first, then a full 7 / 3 run and one extra
  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b1);
    repeat (6) send_request(1'b0);
    send_request(1'b0);
    drain_results();
  endtask

  // register extremes, size zero, oversize clamp, step zero, mid-run restart
  task automatic test_extreme_settings();
    set_config(1'b1, 10'd1, 1'b1, 10'd1023);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();
    set_config(1'b1, 10'd64, 1'b1, 10'd1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    drain_results();
    set_config(1'b1, 10'd0, 1'b0, '0);
    send_request(1'b1);
    drain_results();
    // upper data bits set, masked to 127 then clamped to the ring depth
    set_config(1'b1, 10'h3FF, 1'b1, 10'd0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    drain_results();
    set_config(1'b0, '0, 1'b1, 10'd1023);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain_results();
    set_config(1'b1, 10'd5, 1'b1, 10'd2);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    drain_results();
  endtask

  // random settings, mostly complete eliminations with some noise
  task automatic test_random_circles();
    int unsigned       pick;
    int unsigned       extra;
    logic [DATA_W-1:0] size_word;
    logic [DATA_W-1:0] step_word;
    while (requests_sent < RANDOM_ITEMS + 25) begin
      drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 5)       size_word = 10'd0;
      else if (pick < 9)  size_word = 10'd64;
      else if (pick < 12) size_word = DATA_W'($urandom_range(65, 127));
      else if (pick < 16) size_word = DATA_W'($urandom_range(0, 1023));
      else                size_word = DATA_W'($urandom_range(1, 12));
      pick = $urandom_range(0, 99);
      if (pick < 5)       step_word = 10'd0;
      else if (pick < 10) step_word = 10'd1023;
      else if (pick < 22) step_word = DATA_W'($urandom_range(1, 1023));
      else                step_word = DATA_W'($urandom_range(1, 16));
      set_config($urandom_range(0, 3) != 0, size_word, $urandom_range(0, 3) != 0, step_word);
      case ($urandom_range(0, 2))
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 25;
        default: sender_idle_pct = 50;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // full elimination, now and then restarted midway
        send_request(1'b1);
        while (people_left > 0 && requests_sent < RANDOM_ITEMS + 25)
          send_request($urandom_range(0, 19) == 0);
        extra = $urandom_range(0, 2);
        repeat (extra) send_request(1'b0);
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 10)) send_request($urandom_range(0, 1));
      end else begin
        repeat ($urandom_range(1, 5)) send_request(1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_settings();
    test_random_circles();
    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
